@@ src/tls_request_response_segmenter_assert.svh @@
`ifndef TLS_REQUEST_RESPONSE_SEGMENTER_ASSERT_SVH
`define TLS_REQUEST_RESPONSE_SEGMENTER_ASSERT_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define TRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Antecedent holds -> consequent holds in the next cycle.
`define TRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ src/tlsrrs_pkg.sv @@
package tlsrrs_pkg;

  localparam logic [7:0]  APP_DATA_TYPE     = 8'd23;
  localparam logic [15:0] HDR_TLS13_DEFAULT = 16'd22;
  localparam logic [15:0] HDR_OTHER         = 16'd29;
  localparam logic [15:0] MIN_REQ_RESET     = 16'd60;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TLS13_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TLS13_HDR_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REQ_LEN   = 2'd2;

  localparam int unsigned IN_TDATA_W  = 208;
  localparam int unsigned OUT_TDATA_W = 360;

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_REQ  = 3'b010,
    PH_RESP = 3'b100
  } phase_e;

  // Packed from the lowest bit up: content_type first.
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] server_pkt_mark;
    logic [39:0] last_time;
    logic [39:0] first_time;
    logic [31:0] last_pkt_no;
    logic [31:0] first_pkt_no;
    logic [15:0] record_len;
    logic        from_client;
    logic [7:0]  content_type;
  } in_word_t;

  // Packed from the lowest bit up: req_pkt_no first.
  typedef struct packed {
    logic [31:0] resp_payload_est;
    logic [15:0] resp_first_len;
    logic [31:0] resp_bytes;
    logic [15:0] resp_rec_count;
    logic [31:0] req_bytes;
    logic [15:0] req_rec_count;
    logic [31:0] resp_pkt_span;
    logic [39:0] resp_end_time;
    logic [39:0] resp_begin_time;
    logic [31:0] resp_pkt_no;
    logic [39:0] req_time;
    logic [31:0] req_pkt_no;
  } out_word_t;

endpackage

@@ src/tls_request_response_segmenter.sv @@
// TLS request/response segmenter: takes the application-data records of one
// flow in order (tuser = 1 marks end of flow) and emits one word per finished
// request/response unit. Every record is folded into the unit accumulators in
// the cycle it is accepted, so one word is taken per clock unless the output
// stalls; the only storage between the two sides is the output register, which
// refills in the cycle it is drained. Config is written via cfg, always ready.
module tls_request_response_segmenter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [tlsrrs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tlsrrs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // content_type, from_client, record_len, first_pkt_no, last_pkt_no,
  // first_time, last_time, server_pkt_mark, zero pad
  input  logic [tlsrrs_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // cmd (1 = end of flow)
  input  logic                                   s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // req_pkt_no, req_time, resp_pkt_no, resp_begin_time, resp_end_time,
  // resp_pkt_span, req_rec_count, req_bytes, resp_rec_count, resp_bytes,
  // resp_first_len, resp_payload_est
  output logic [tlsrrs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);

  logic        tls13_mode_q;
  logic [15:0] tls13_hdr_len_q;
  logic [15:0] min_req_len_q;

  tlsrrs_pkg::phase_e phase_q, phase_d;
  logic [31:0] req_pkt_q, req_pkt_d;
  logic [39:0] req_tick_q, req_tick_d;
  logic [31:0] resp_pkt_q, resp_pkt_d;
  logic [39:0] resp_begin_q, resp_begin_d;
  logic [39:0] resp_end_q, resp_end_d;
  logic [31:0] start_mark_q, start_mark_d;
  logic [15:0] req_count_q, req_count_d;
  logic [31:0] req_sum_q, req_sum_d;
  logic [15:0] resp_count_q, resp_count_d;
  logic [31:0] resp_sum_q, resp_sum_d;
  logic [15:0] resp_first_q, resp_first_d;
  logic [31:0] resp_est_q, resp_est_d;

  logic                  out_valid_q;
  tlsrrs_pkg::out_word_t out_word_q, out_word_d;
  logic                  emit;

  tlsrrs_pkg::in_word_t in_w;
  logic        accept;
  logic        is_app;
  logic [15:0] hdr_len;
  logic [15:0] est;
  logic [16:0] req_count_inc, resp_count_inc;
  logic [32:0] req_sum_add, resp_sum_add, resp_est_add;

  assign in_w            = s_axis_tdata_i;
  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_app          = in_w.content_type == tlsrrs_pkg::APP_DATA_TYPE;

  always_comb begin
    if (tls13_mode_q) begin
      hdr_len = (tls13_hdr_len_q == 16'd0) ? tlsrrs_pkg::HDR_TLS13_DEFAULT : tls13_hdr_len_q;
    end else begin
      hdr_len = tlsrrs_pkg::HDR_OTHER;
    end
  end

  assign est            = (in_w.record_len > hdr_len) ? in_w.record_len - hdr_len : 16'd0;
  assign req_count_inc  = {1'b0, req_count_q} + 17'd1;
  assign resp_count_inc = {1'b0, resp_count_q} + 17'd1;
  assign req_sum_add    = {1'b0, req_sum_q} + {17'd0, in_w.record_len};
  assign resp_sum_add   = {1'b0, resp_sum_q} + {17'd0, in_w.record_len};
  assign resp_est_add   = {1'b0, resp_est_q} + {17'd0, est};

  // Result word reflects the state before this record's update, except resp_pkt_span, which uses this record's mark.
  always_comb begin
    out_word_d.req_pkt_no       = req_pkt_q;
    out_word_d.req_time         = req_tick_q;
    out_word_d.resp_pkt_no      = resp_pkt_q;
    out_word_d.resp_begin_time  = resp_begin_q;
    out_word_d.resp_end_time    = resp_end_q;
    out_word_d.resp_pkt_span    = in_w.server_pkt_mark - start_mark_q;
    out_word_d.req_rec_count    = req_count_q;
    out_word_d.req_bytes        = req_sum_q;
    out_word_d.resp_rec_count   = resp_count_q;
    out_word_d.resp_bytes       = resp_sum_q;
    out_word_d.resp_first_len   = resp_first_q;
    out_word_d.resp_payload_est = resp_est_q;
  end

  always_comb begin
    phase_d      = phase_q;
    req_pkt_d    = req_pkt_q;
    req_tick_d   = req_tick_q;
    resp_pkt_d   = resp_pkt_q;
    resp_begin_d = resp_begin_q;
    resp_end_d   = resp_end_q;
    start_mark_d = start_mark_q;
    req_count_d  = req_count_q;
    req_sum_d    = req_sum_q;
    resp_count_d = resp_count_q;
    resp_sum_d   = resp_sum_q;
    resp_first_d = resp_first_q;
    resp_est_d   = resp_est_q;
    emit         = 1'b0;
    if (s_axis_tuser_i) begin
      // end of flow: flush a unit in its response phase, then back to a clean slate
      emit         = phase_q == tlsrrs_pkg::PH_RESP;
      phase_d      = tlsrrs_pkg::PH_WAIT;
      req_pkt_d    = '0;
      req_tick_d   = '0;
      resp_pkt_d   = '0;
      resp_begin_d = '0;
      resp_end_d   = '0;
      start_mark_d = '0;
      req_count_d  = '0;
      req_sum_d    = '0;
      resp_count_d = '0;
      resp_sum_d   = '0;
      resp_first_d = '0;
      resp_est_d   = '0;
    end else if (is_app) begin
      unique case (phase_q)
        tlsrrs_pkg::PH_REQ: begin
          if (in_w.from_client) begin
            req_count_d = req_count_inc[16] ? 16'hFFFF : req_count_inc[15:0];
            req_sum_d   = req_sum_add[32] ? 32'hFFFF_FFFF : req_sum_add[31:0];
          end else begin
            phase_d      = tlsrrs_pkg::PH_RESP;
            resp_sum_d   = {16'd0, in_w.record_len};
            resp_first_d = in_w.record_len;
            resp_est_d   = {16'd0, est};
            resp_count_d = 16'd1;
            resp_pkt_d   = in_w.first_pkt_no;
            resp_begin_d = in_w.first_time;
            resp_end_d   = in_w.last_time;
          end
        end
        tlsrrs_pkg::PH_RESP: begin
          if (in_w.from_client) begin
            if (in_w.record_len > min_req_len_q) begin
              emit         = 1'b1;
              phase_d      = tlsrrs_pkg::PH_REQ;
              req_count_d  = 16'd1;
              req_sum_d    = {16'd0, in_w.record_len};
              req_pkt_d    = in_w.first_pkt_no;
              req_tick_d   = in_w.first_time;
              start_mark_d = in_w.server_pkt_mark;
            end
          end else begin
            resp_sum_d   = resp_sum_add[32] ? 32'hFFFF_FFFF : resp_sum_add[31:0];
            resp_est_d   = resp_est_add[32] ? 32'hFFFF_FFFF : resp_est_add[31:0];
            resp_count_d = resp_count_inc[16] ? 16'hFFFF : resp_count_inc[15:0];
            resp_end_d   = in_w.last_time;
          end
        end
        default: begin
          if (in_w.from_client) begin
            phase_d      = tlsrrs_pkg::PH_REQ;
            req_count_d  = 16'd1;
            req_sum_d    = {16'd0, in_w.record_len};
            req_pkt_d    = in_w.last_pkt_no;
            req_tick_d   = in_w.last_time;
            start_mark_d = in_w.server_pkt_mark;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tls13_mode_q    <= 1'b0;
      tls13_hdr_len_q <= '0;
      min_req_len_q   <= tlsrrs_pkg::MIN_REQ_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tlsrrs_pkg::CFG_TLS13_MODE:    tls13_mode_q    <= cfg_data_i[0];
        tlsrrs_pkg::CFG_TLS13_HDR_LEN: tls13_hdr_len_q <= cfg_data_i;
        tlsrrs_pkg::CFG_MIN_REQ_LEN:   min_req_len_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= tlsrrs_pkg::PH_WAIT;
      req_pkt_q    <= '0;
      req_tick_q   <= '0;
      resp_pkt_q   <= '0;
      resp_begin_q <= '0;
      resp_end_q   <= '0;
      start_mark_q <= '0;
      req_count_q  <= '0;
      req_sum_q    <= '0;
      resp_count_q <= '0;
      resp_sum_q   <= '0;
      resp_first_q <= '0;
      resp_est_q   <= '0;
    end else if (accept) begin
      phase_q      <= phase_d;
      req_pkt_q    <= req_pkt_d;
      req_tick_q   <= req_tick_d;
      resp_pkt_q   <= resp_pkt_d;
      resp_begin_q <= resp_begin_d;
      resp_end_q   <= resp_end_d;
      start_mark_q <= start_mark_d;
      req_count_q  <= req_count_d;
      req_sum_q    <= req_sum_d;
      resp_count_q <= resp_count_d;
      resp_sum_q   <= resp_sum_d;
      resp_first_q <= resp_first_d;
      resp_est_q   <= resp_est_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_word_q <= out_word_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_word_q;

endmodule

@@ src/tlsrrs_checker.sv @@
`include "tls_request_response_segmenter_assert.svh"

module tlsrrs_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid_i,
  input logic                               s_axis_tready_o,
  input logic [tlsrrs_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                               s_axis_tuser_i,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [tlsrrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic stall;
  logic drained;
  logic ignored;

  assign stall   = m_axis_tvalid_o && !m_axis_tready_i;
  assign drained = m_axis_tready_i || !m_axis_tvalid_o;
  // non-application-data record: never yields a word
  assign ignored = s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i &&
                   (s_axis_tdata_i[7:0] != tlsrrs_pkg::APP_DATA_TYPE);

  `TRS_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, stall, m_axis_tvalid_o)
  `TRS_ASSERT_NEXT(a_out_data_holds, clk_i, rst_ni, stall, $stable(m_axis_tdata_o))
  `TRS_ASSERT_SAME(a_ready_when_drained, clk_i, rst_ni, drained, s_axis_tready_o)
  `TRS_ASSERT_NEXT(a_ignored_no_word, clk_i, rst_ni, ignored, !m_axis_tvalid_o)

endmodule

bind tls_request_response_segmenter tlsrrs_checker u_tlsrrs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
